[rtl/b2d_pkg.sv]
// Shared types and constants for the binary to decimal character writer.
`timescale 1ns / 1ps

package b2d_pkg;

    localparam int unsigned COL_W      = 8;
    localparam int unsigned ROW_W      = 7;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CHAR_W     = 6;
    localparam int unsigned OFFSET_W   = 13;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
    localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
    localparam int unsigned ROW_SHIFT  = 7;

    localparam logic [CHAR_W-5:0] CHAR_ZERO_HI = 2'b11;
    localparam logic [3:0]        BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0]        BCD_ADJ_ADD  = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EMIT
    } t_state;

endpackage

[rtl/b2d_if.sv]
// Item channel interfaces for the binary to decimal character writer.
`timescale 1ns / 1ps

interface b2d_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [b2d_pkg::COL_W-1:0]      start_column;
    logic signed [b2d_pkg::ROW_W-1:0]      start_row;
    logic        [b2d_pkg::VALUE_W-1:0]    number_value;

    modport source (output valid, start_column, start_row, number_value, input ready);
    modport sink   (input valid, start_column, start_row, number_value, output ready);
endinterface

interface b2d_out_if;
    logic                              valid;
    logic                              ready;
    logic [b2d_pkg::CHAR_W-1:0]        char_code;
    logic [b2d_pkg::OFFSET_W-1:0]      cell_offset;
    logic                              write_valid;
    logic [b2d_pkg::COUNT_W-1:0]       digit_count;
    logic                              last_digit;

    modport source (output valid, char_code, cell_offset, write_valid, digit_count,
                    last_digit, input ready);
    modport sink   (input valid, char_code, cell_offset, write_valid, digit_count,
                    last_digit, output ready);
endinterface

[rtl/binary_to_decimal_char_writer.sv]
// Binary to decimal ASCII character writer with leading zero suppression.
// Steps: shift-add-3 conversion of the input bits, then normalize steps that drop
// leading zero digits; then the digits are emitted most significant first, one digit
// per cycle while o_item.ready is high. A new input item is accepted only once the
// last digit has been taken, since the serial BCD shift register serves one item at a time.
// Reset: synchronous active-low i_rst_n returns the controller to idle.
`timescale 1ns / 1ps

module binary_to_decimal_char_writer #(
    parameter int GRID_COLUMNS = 80,
    parameter int GRID_ROWS    = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b2d_in_if.sink            i_item,
    b2d_out_if.source         o_item
);

    localparam logic signed [b2d_pkg::COL_W:0] COL_LIM = (b2d_pkg::COL_W+1)'(GRID_COLUMNS);
    localparam logic signed [b2d_pkg::ROW_W:0] ROW_LIM = (b2d_pkg::ROW_W+1)'(GRID_ROWS);

    b2d_pkg::t_state                     r_state, n_state;
    logic [b2d_pkg::VALUE_W-1:0]         r_bin, n_bin;
    logic [b2d_pkg::BCD_W-1:0]           r_bcd, n_bcd;
    logic [b2d_pkg::BIT_CNT_W-1:0]       r_bit, n_bit;
    logic [b2d_pkg::COUNT_W-1:0]         r_cnt, n_cnt;
    logic [b2d_pkg::COUNT_W-1:0]         r_left, n_left;
    logic signed [b2d_pkg::COL_W:0]      r_col, n_col;
    logic signed [b2d_pkg::ROW_W-1:0]    r_row, n_row;

    logic [b2d_pkg::BCD_W-1:0]           bcd_adj;
    logic [3:0]                          top_digit;
    logic                                cell_ok;

    always_comb begin
        for (int d = 0; d < b2d_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= b2d_pkg::BCD_ADJ_MIN) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + b2d_pkg::BCD_ADJ_ADD;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    assign top_digit = r_bcd[b2d_pkg::BCD_W-1 -: 4];
    assign cell_ok   = (r_col >= 0) && (r_col < COL_LIM)
                    && (r_row >= 0) && ({r_row[b2d_pkg::ROW_W-1], r_row} < ROW_LIM);

    assign i_item.ready       = (r_state == b2d_pkg::ST_IDLE);
    assign o_item.valid       = (r_state == b2d_pkg::ST_EMIT);
    assign o_item.char_code   = {b2d_pkg::CHAR_ZERO_HI, top_digit};
    assign o_item.write_valid = cell_ok;
    assign o_item.cell_offset = cell_ok
        ? {r_row[b2d_pkg::ROW_W-2:0], r_col[b2d_pkg::ROW_SHIFT-1:0]}
        : '0;
    assign o_item.digit_count = r_cnt;
    assign o_item.last_digit  = (r_left == b2d_pkg::COUNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2d_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_col  <= n_col;
        r_row  <= n_row;
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_col   = r_col;
        n_row   = r_row;
        unique case (r_state)
            b2d_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_bin   = i_item.number_value;
                    n_bcd   = '0;
                    n_bit   = '0;
                    n_cnt   = b2d_pkg::COUNT_W'(b2d_pkg::NUM_DIGITS);
                    n_col   = {i_item.start_column[b2d_pkg::COL_W-1], i_item.start_column};
                    n_row   = i_item.start_row;
                    n_state = b2d_pkg::ST_CONV;
                end
            end
            b2d_pkg::ST_CONV: begin
                n_bcd = {bcd_adj[b2d_pkg::BCD_W-2:0], r_bin[b2d_pkg::VALUE_W-1]};
                n_bin = {r_bin[b2d_pkg::VALUE_W-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (r_bit == b2d_pkg::BIT_CNT_W'(b2d_pkg::VALUE_W - 1)) begin
                    n_state = b2d_pkg::ST_NORM;
                end
            end
            b2d_pkg::ST_NORM: begin
                if ((top_digit == 4'd0) && (r_cnt > b2d_pkg::COUNT_W'(1))) begin
                    n_bcd = {r_bcd[b2d_pkg::BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_left  = r_cnt;
                    n_state = b2d_pkg::ST_EMIT;
                end
            end
            b2d_pkg::ST_EMIT: begin
                if (o_item.ready) begin
                    n_bcd  = {r_bcd[b2d_pkg::BCD_W-5:0], 4'd0};
                    n_col  = r_col + 1'b1;
                    n_left = r_left - 1'b1;
                    if (r_left == b2d_pkg::COUNT_W'(1)) begin
                        n_state = b2d_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = b2d_pkg::ST_IDLE;
        endcase
    end

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == b2d_pkg::ST_CONV) && (r_bit == '0))
        else $error("accepted item did not start conversion");

    a_emit_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item.valid |-> (top_digit <= 4'd9) && (r_left != '0) && (r_left <= r_cnt)
                         && (r_cnt <= b2d_pkg::COUNT_W'(b2d_pkg::NUM_DIGITS)))
        else $error("emitted digit or counters out of range");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && o_item.ready && o_item.last_digit) |=> i_item.ready)
        else $error("controller not idle after last digit");

    a_write_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && !o_item.write_valid) |-> (o_item.cell_offset == '0))
        else $error("offset nonzero on an item outside the grid");

endmodule

[tb/b2d_result_checker.sv]
// Checker that predicts the digit writes of each accepted number and compares them.
`timescale 1ns / 1ps

module b2d_result_checker #(
    parameter int GRID_COLUMNS = 80,
    parameter int GRID_ROWS    = 60
) (
    input  logic i_clk,
    input  logic i_rst_n,
    b2d_in_if    in_ch,
    b2d_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int ASCII_ZERO   = 48;
    localparam int DECIMAL_BASE = 10;

    typedef struct packed {
        logic [b2d_pkg::CHAR_W-1:0]   char_code;
        logic [b2d_pkg::OFFSET_W-1:0] cell_offset;
        logic                         write_valid;
        logic [b2d_pkg::COUNT_W-1:0]  digit_count;
        logic                         last_digit;
    } t_digit_write;

    t_digit_write pending_writes[$];
    int           fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void predict_writes(input logic signed [b2d_pkg::COL_W-1:0] col0,
                                           input logic signed [b2d_pkg::ROW_W-1:0] row,
                                           input logic [b2d_pkg::VALUE_W-1:0] value);
        logic [3:0]                  digs[b2d_pkg::NUM_DIGITS];
        logic [b2d_pkg::VALUE_W-1:0] rest;
        int                          n;
        int                          col;
        int                          row_i;
        logic                        in_grid;
        t_digit_write                w;
        n     = 0;
        rest  = value;
        row_i = int'(row);
        do begin
            digs[n] = 4'(rest % DECIMAL_BASE);
            rest    = rest / DECIMAL_BASE;
            n++;
        end while (rest != 0 && n < b2d_pkg::NUM_DIGITS);
        for (int k = 0; k < n; k++) begin
            col     = int'(col0) + k;
            in_grid = col >= 0 && col < GRID_COLUMNS && row_i >= 0 && row_i < GRID_ROWS;
            w.char_code   = b2d_pkg::CHAR_W'(ASCII_ZERO + int'(digs[n-1-k]));
            w.cell_offset = in_grid
                ? b2d_pkg::OFFSET_W'((row_i << b2d_pkg::ROW_SHIFT) + col) : '0;
            w.write_valid = in_grid;
            w.digit_count = b2d_pkg::COUNT_W'(n);
            w.last_digit  = (k == n - 1);
            pending_writes.push_back(w);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_write want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_writes.size() == 0) begin
                    $error("char_code expected none actual %0d", out_ch.char_code);
                    fail_total++;
                end else begin
                    want = pending_writes.pop_front();
                    check_field("char_code", want.char_code, out_ch.char_code);
                    check_field("cell_offset", want.cell_offset, out_ch.cell_offset);
                    check_field("write_valid", want.write_valid, out_ch.write_valid);
                    check_field("digit_count", want.digit_count, out_ch.digit_count);
                    check_field("last_digit", want.last_digit, out_ch.last_digit);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_writes(in_ch.start_column, in_ch.start_row, in_ch.number_value);
            end
        end
        o_pending    = pending_writes.size();
        o_fail_count = fail_total;
    end

endmodule

[tb/binary_to_decimal_char_writer_test.sv]
// Top of the testbench: clock, reset, number stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module binary_to_decimal_char_writer_test;

    localparam int GRID_COLUMNS = 80;
    localparam int GRID_ROWS    = 60;
    localparam int RANDOM_ITEMS = 330;
    localparam int HOLD_START   = 4000;
    localparam int HOLD_LEN     = 800;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   fail_count;
    int   pending;

    b2d_in_if  in_ch();
    b2d_out_if out_ch();

    binary_to_decimal_char_writer #(
        .GRID_COLUMNS(GRID_COLUMNS),
        .GRID_ROWS   (GRID_ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (in_ch),
        .o_item (out_ch)
    );

    b2d_result_checker #(
        .GRID_COLUMNS(GRID_COLUMNS),
        .GRID_ROWS   (GRID_ROWS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [b2d_pkg::VALUE_W-1:0] value_with_digits(input int n);
        longint lo;
        longint hi;
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (n == 1) begin
            lo = 0;
        end
        if (hi > 64'hFFFF_FFFF) begin
            hi = 64'hFFFF_FFFF;
        end
        return b2d_pkg::VALUE_W'(lo + longint'({32'h0, $urandom()}) % (hi - lo + 1));
    endfunction

    task automatic offer_number(input logic signed [b2d_pkg::COL_W-1:0] col,
                                input logic signed [b2d_pkg::ROW_W-1:0] row,
                                input logic [b2d_pkg::VALUE_W-1:0] value);
        int unsigned gap;
        in_ch.start_column = col;
        in_ch.start_row    = row;
        in_ch.number_value = value;
        in_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        gap = no_idle ? 0 : gap_length();
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        int unsigned sink_cycles;
        int unsigned stall_left;
        sink_cycles  = 0;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            sink_cycles++;
            if (sink_cycles >= HOLD_START && sink_cycles < HOLD_START + HOLD_LEN) begin
                out_ch.ready = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
                if (!no_idle) begin
                    stall_left = gap_length();
                end
            end
        end
    end

    initial begin
        logic signed [b2d_pkg::COL_W-1:0] col;
        logic signed [b2d_pkg::ROW_W-1:0] row;
        logic [b2d_pkg::VALUE_W-1:0]      value;
        int unsigned                      pick;
        in_ch.valid        = 1'b0;
        in_ch.start_column = '0;
        in_ch.start_row    = '0;
        in_ch.number_value = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        offer_number(8'sd0, 7'sd0, 32'd0);
        offer_number(8'sd0, 7'sd0, 32'd9);
        offer_number(8'sd0, 7'sd0, 32'd10);
        offer_number(8'sd0, 7'sd0, 32'hFFFF_FFFF);
        offer_number(8'sd0, 7'sd1, 32'd1_000_000_000);
        offer_number(8'sd0, 7'sd2, 32'd999_999_999);
        offer_number(8'sd79, 7'sd59, 32'd5);
        offer_number(8'sd80, 7'sd59, 32'd5);
        offer_number(8'sd79, 7'sd60, 32'd5);
        offer_number(-8'sd1, 7'sd0, 32'd7);
        offer_number(8'sd0, -7'sd1, 32'd7);
        offer_number(-8'sd128, -7'sd64, 32'hFFFF_FFFF);
        offer_number(8'sd127, 7'sd63, 32'd0);
        offer_number(8'sd75, 7'sd10, 32'hFFFF_FFFF);
        offer_number(-8'sd3, 7'sd5, 32'd123_456);
        offer_number(8'sd70, 7'sd0, 32'd1_234_567_890);
        offer_number(-8'sd5, 7'sd59, 32'd99_999);
        offer_number(8'sd0, 7'sd63, 32'd42);
        offer_number(8'sd127, 7'sd0, 32'h8000_0000);
        offer_number(8'sd0, 7'sd60, 32'd1);
        offer_number(8'sd1, 7'sd1, 32'd100);
        offer_number(8'sd120, -7'sd20, 32'h5555_5555);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 120 && i < 170);
            pick    = $urandom_range(0, 99);
            if (pick < 80) begin
                col   = ($urandom_range(0, 9) < 8)
                      ? b2d_pkg::COL_W'($urandom_range(0, GRID_COLUMNS - 1))
                      : b2d_pkg::COL_W'($urandom());
                row   = ($urandom_range(0, 9) < 8)
                      ? b2d_pkg::ROW_W'($urandom_range(0, GRID_ROWS - 1))
                      : b2d_pkg::ROW_W'($urandom());
                value = value_with_digits($urandom_range(1, b2d_pkg::NUM_DIGITS));
            end else begin
                col   = b2d_pkg::COL_W'($urandom());
                row   = b2d_pkg::ROW_W'($urandom());
                value = $urandom() >> $urandom_range(0, 31);
            end
            offer_number(col, row, value);
        end
        no_idle     = 1'b0;
        in_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
